FILE: rtl/frea_pkg.sv
package frea_pkg;

  localparam int MAX_EXTENTS_DEF = 16;
  localparam int ADDR_BITS_DEF = 32;
  localparam int LEN_BITS = 31;
  localparam logic [LEN_BITS-1:0] LEN_MAX = '1;

  typedef enum logic [1:0] {
    MODE_ALLOC_LO = 2'd0,
    MODE_ALLOC_HI = 2'd1,
    MODE_RELEASE  = 2'd2,
    MODE_RESERVE  = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_INSERT,
    OP_DELETE,
    OP_ALLOC_LO,
    OP_ALLOC_HI,
    OP_RESERVE,
    OP_MERGE
  } cell_op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_SCAN,
    S_APPLY,
    S_INSERT,
    S_COMPACT,
    S_MERGE,
    S_DONE
  } state_t;

  typedef struct packed {
    cell_op_t op;
    logic     at;
    logic     above;
    logic     nxt;
    logic     mhit;
    logic     mfit;
  } cell_ctl_t;

  typedef struct packed {
    logic fit;
    logic ge;
    logic split;
    logic zero;
    logic hit;
    logic fits;
  } cell_flag_t;

endpackage

FILE: rtl/frea_cell.sv
module frea_cell #(
  parameter int ADDR_BITS = frea_pkg::ADDR_BITS_DEF
) (
  input  logic                          clk,
  input  frea_pkg::cell_ctl_t           ctl,
  input  logic [ADDR_BITS-1:0]          ins_start,
  input  logic [frea_pkg::LEN_BITS-1:0] ins_len,
  input  logic [ADDR_BITS-1:0]          req_addr,
  input  logic [ADDR_BITS-1:0]          req_last,
  input  logic [frea_pkg::LEN_BITS-1:0] req_size,
  input  logic [ADDR_BITS-1:0]          left_start,
  input  logic [frea_pkg::LEN_BITS-1:0] left_len,
  input  logic [ADDR_BITS-1:0]          left_rem_start,
  input  logic [frea_pkg::LEN_BITS-1:0] left_rem_len,
  input  logic [ADDR_BITS-1:0]          right_start,
  input  logic [frea_pkg::LEN_BITS-1:0] right_len,
  output logic [ADDR_BITS-1:0]          start,
  output logic [frea_pkg::LEN_BITS-1:0] len,
  output logic [ADDR_BITS-1:0]          rem_start,
  output logic [frea_pkg::LEN_BITS-1:0] rem_len,
  output frea_pkg::cell_flag_t          flags
);
  import frea_pkg::*;

  localparam int WB = (ADDR_BITS > LEN_BITS ? ADDR_BITS : LEN_BITS) + 1;

  logic [ADDR_BITS-1:0] st, st_next;
  logic [LEN_BITS-1:0]  ln, ln_next;
  logic [ADDR_BITS-1:0] elast;
  logic [ADDR_BITS-1:0] gap;
  logic [WB-1:0]        span;
  logic [WB-1:0]        tot;
  logic                 ovl;

  assign start = st;
  assign len = ln;

  // extent vs. request and vs. right neighbor
  always_comb begin
    elast = st + ADDR_BITS'(ln) - ADDR_BITS'(1);
    gap = right_start - st;
    span = WB'(gap) + WB'(right_len);
    tot = (WB'(ln) > span) ? WB'(ln) : span;
    ovl = (req_addr <= elast) && (req_last >= st);
    flags.fit = ln >= req_size;
    flags.ge = st >= req_addr;
    flags.split = ovl && (st < req_addr) && (elast > req_last);
    flags.zero = ln == '0;
    flags.hit = WB'(gap) <= WB'(ln);
    flags.fits = tot <= WB'(LEN_MAX);
    rem_start = st + ADDR_BITS'(LEN_MAX);
    rem_len = LEN_BITS'(tot - WB'(LEN_MAX));
  end

  always_comb begin
    st_next = st;
    ln_next = ln;
    case (ctl.op)
      OP_INSERT: begin
        if (ctl.at) begin
          st_next = ins_start;
          ln_next = ins_len;
        end else if (ctl.above) begin
          st_next = left_start;
          ln_next = left_len;
        end
      end
      OP_DELETE: begin
        if (ctl.at || ctl.above) begin
          st_next = right_start;
          ln_next = right_len;
        end
      end
      OP_ALLOC_LO: begin
        if (ctl.at) begin
          st_next = st + ADDR_BITS'(req_size);
          ln_next = ln - req_size;
        end
      end
      OP_ALLOC_HI: begin
        if (ctl.at) begin
          ln_next = ln - req_size;
        end
      end
      OP_RESERVE: begin
        if (ovl) begin
          if (req_addr <= st) begin
            if (req_last >= elast) begin
              ln_next = '0;
            end else begin
              st_next = req_last + ADDR_BITS'(1);
              ln_next = LEN_BITS'(elast - req_last);
            end
          end else begin
            ln_next = LEN_BITS'(req_addr - st);
          end
        end
      end
      OP_MERGE: begin
        if (ctl.at && ctl.mhit) begin
          ln_next = ctl.mfit ? LEN_BITS'(tot) : LEN_MAX;
        end else if (ctl.nxt && ctl.mhit && !ctl.mfit) begin
          st_next = left_rem_start;
          ln_next = left_rem_len;
        end else if (ctl.above && ctl.mhit && ctl.mfit) begin
          st_next = right_start;
          ln_next = right_len;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    st <= st_next;
    ln <= ln_next;
  end

endmodule

FILE: rtl/free_extent_range_allocator.sv
// channel | valid     | stall     | payload
// in      | in_valid  | in_stall  | mode, range_address, request_size
// out     | out_valid | out_stall | granted_address, granted_size, ok
//
// one item at a time, from accept through prep, the steps below and done
// zero size or full-table release: none; allocate: scan, apply, compact on fit
// reserve: scan, apply, compact or insert (compaction deletes one cell a cycle)
// release: scan, apply, insert, merge (merge token walks the cell row)
// rst clears the fill count and the handshake; the table starts empty
// a result held by out_stall keeps the block in done, which stalls the next item
module free_extent_range_allocator #(
  parameter int MAX_EXTENTS = frea_pkg::MAX_EXTENTS_DEF,
  parameter int ADDR_BITS = frea_pkg::ADDR_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    mode,
  input  logic [31:0]                   range_address,
  input  logic [frea_pkg::LEN_BITS-1:0] request_size,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [31:0]                   granted_address,
  output logic [frea_pkg::LEN_BITS-1:0] granted_size,
  output logic                          ok
);
  import frea_pkg::*;

  localparam int IW = $clog2(MAX_EXTENTS);
  localparam int CW = $clog2(MAX_EXTENTS + 1);
  localparam int WB = (ADDR_BITS > LEN_BITS ? ADDR_BITS : LEN_BITS) + 1;
  localparam logic [ADDR_BITS-1:0] AMASK = '1;
  localparam logic [CW-1:0] FULL = CW'(MAX_EXTENTS);

  state_t               state, state_next;
  logic [CW-1:0]        count, count_next;
  logic [IW-1:0]        tok, tok_next;
  logic [IW-1:0]        pos_r;
  mode_t                mode_r;
  logic [ADDR_BITS-1:0] addr_r, last_r, ins_start_r;
  logic [LEN_BITS-1:0]  size_r, n_r, ins_len_r;
  logic [31:0]          res_addr;
  logic [LEN_BITS-1:0]  res_size;
  logic                 res_ok;
  logic [MAX_EXTENTS-1:0] fitv, gev, splitv;

  logic [ADDR_BITS-1:0] c_start [MAX_EXTENTS];
  logic [LEN_BITS-1:0]  c_len [MAX_EXTENTS];
  logic [ADDR_BITS-1:0] c_rem_start [MAX_EXTENTS];
  logic [LEN_BITS-1:0]  c_rem_len [MAX_EXTENTS];
  logic [ADDR_BITS-1:0] l_start [MAX_EXTENTS];
  logic [LEN_BITS-1:0]  l_len [MAX_EXTENTS];
  logic [ADDR_BITS-1:0] l_rem_start [MAX_EXTENTS];
  logic [LEN_BITS-1:0]  l_rem_len [MAX_EXTENTS];
  logic [ADDR_BITS-1:0] r_start [MAX_EXTENTS];
  logic [LEN_BITS-1:0]  r_len [MAX_EXTENTS];
  cell_flag_t           c_flag [MAX_EXTENTS];
  cell_ctl_t            c_ctl [MAX_EXTENTS];

  logic [MAX_EXTENTS-1:0] live, fit_w, ge_w, split_w, zero_w;
  logic [MAX_EXTENTS-1:0] at_v, above_v, nxt_v;

  cell_op_t      op;
  logic [IW-1:0] pos;
  logic          mhit, mfit;

  logic          fit_any, split_any, zero_any, full, merge_end, load;
  logic [IW-1:0] fit_first, fit_last, ge_first, split_idx, zero_first, rd_idx;
  logic [ADDR_BITS-1:0] rd_start, rd_elast, room;
  logic [LEN_BITS-1:0]  rd_len;
  logic          clip;
  cell_flag_t    tok_flag;

  assign in_stall = state != S_IDLE;
  assign full = count == FULL;
  assign load = (state == S_DONE) && (!out_valid || !out_stall);

  for (genvar k = 0; k < MAX_EXTENTS; k++) begin : g_row
    assign live[k] = CW'(k) < count;
    assign fit_w[k] = c_flag[k].fit;
    assign ge_w[k] = c_flag[k].ge;
    assign split_w[k] = c_flag[k].split;
    assign zero_w[k] = c_flag[k].zero;
    assign at_v[k] = pos == IW'(k);
    assign above_v[k] = IW'(k) > pos;
    if (k == 0) begin : g_first
      assign nxt_v[k] = 1'b0;
      assign l_start[k] = '0;
      assign l_len[k] = '0;
      assign l_rem_start[k] = '0;
      assign l_rem_len[k] = '0;
    end else begin : g_mid
      assign nxt_v[k] = pos == IW'(k - 1);
      assign l_start[k] = c_start[k-1];
      assign l_len[k] = c_len[k-1];
      assign l_rem_start[k] = c_rem_start[k-1];
      assign l_rem_len[k] = c_rem_len[k-1];
    end
    if (k == MAX_EXTENTS - 1) begin : g_last
      assign r_start[k] = '0;
      assign r_len[k] = '0;
    end else begin : g_inner
      assign r_start[k] = c_start[k+1];
      assign r_len[k] = c_len[k+1];
    end
    assign c_ctl[k] = '{op: op, at: at_v[k], above: above_v[k], nxt: nxt_v[k],
                        mhit: mhit, mfit: mfit};

    frea_cell #(.ADDR_BITS(ADDR_BITS)) u_cell (
      .clk            (clk),
      .ctl            (c_ctl[k]),
      .ins_start      (ins_start_r),
      .ins_len        (ins_len_r),
      .req_addr       (addr_r),
      .req_last       (last_r),
      .req_size       (size_r),
      .left_start     (l_start[k]),
      .left_len       (l_len[k]),
      .left_rem_start (l_rem_start[k]),
      .left_rem_len   (l_rem_len[k]),
      .right_start    (r_start[k]),
      .right_len      (r_len[k]),
      .start          (c_start[k]),
      .len            (c_len[k]),
      .rem_start      (c_rem_start[k]),
      .rem_len        (c_rem_len[k]),
      .flags          (c_flag[k])
    );
  end

  // priority picks over the row
  always_comb begin
    fit_any = |(fitv & live);
    split_any = |(splitv & live);
    zero_any = |(zero_w & live);
    fit_first = '0;
    fit_last = '0;
    split_idx = '0;
    zero_first = '0;
    ge_first = count[IW-1:0];
    for (int k = MAX_EXTENTS - 1; k >= 0; k--) begin
      if (fitv[k] && live[k]) fit_first = IW'(k);
      if (gev[k] && live[k]) ge_first = IW'(k);
      if (zero_w[k] && live[k]) zero_first = IW'(k);
    end
    for (int k = 0; k < MAX_EXTENTS; k++) begin
      if (fitv[k] && live[k]) fit_last = IW'(k);
      if (splitv[k] && live[k]) split_idx = IW'(k);
    end
  end

  always_comb begin
    case (mode_r)
      MODE_RESERVE:  rd_idx = split_idx;
      MODE_ALLOC_LO: rd_idx = fit_first;
      default:       rd_idx = fit_last;
    endcase
    rd_start = c_start[rd_idx];
    rd_len = c_len[rd_idx];
    rd_elast = rd_start + ADDR_BITS'(rd_len) - ADDR_BITS'(1);
    tok_flag = c_flag[tok];
    merge_end = (CW'(tok) + CW'(1)) >= count;
    room = AMASK - addr_r;
    clip = WB'(size_r - LEN_BITS'(1)) > WB'(room);
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (in_valid) state_next = S_PREP;
      S_PREP: begin
        if (size_r == '0 || (mode_r == MODE_RELEASE && full)) state_next = S_DONE;
        else state_next = S_SCAN;
      end
      S_SCAN:   state_next = S_APPLY;
      S_APPLY: begin
        case (mode_r)
          MODE_RELEASE: state_next = S_INSERT;
          MODE_RESERVE: begin
            if (!split_any) state_next = S_COMPACT;
            else if (full) state_next = S_DONE;
            else state_next = S_INSERT;
          end
          default: state_next = fit_any ? S_COMPACT : S_DONE;
        endcase
      end
      S_INSERT:  state_next = (mode_r == MODE_RELEASE) ? S_MERGE : S_DONE;
      S_COMPACT: if (!zero_any) state_next = S_DONE;
      S_MERGE:   if (merge_end) state_next = S_DONE;
      S_DONE:    if (load) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  // row commands
  always_comb begin
    op = OP_HOLD;
    pos = pos_r;
    mhit = 1'b0;
    mfit = 1'b0;
    count_next = count;
    tok_next = tok;
    case (state)
      S_APPLY: begin
        tok_next = '0;
        case (mode_r)
          MODE_ALLOC_LO: begin
            if (fit_any) begin
              op = OP_ALLOC_LO;
              pos = fit_first;
            end
          end
          MODE_ALLOC_HI: begin
            if (fit_any) begin
              op = OP_ALLOC_HI;
              pos = fit_last;
            end
          end
          MODE_RESERVE: if (!(split_any && full)) op = OP_RESERVE;
          default: ;
        endcase
      end
      S_INSERT: begin
        op = OP_INSERT;
        count_next = count + CW'(1);
      end
      S_COMPACT: begin
        if (zero_any) begin
          op = OP_DELETE;
          pos = zero_first;
          count_next = count - CW'(1);
        end
      end
      S_MERGE: begin
        if (!merge_end) begin
          pos = tok;
          mhit = tok_flag.hit;
          mfit = tok_flag.fits;
          if (tok_flag.hit) op = OP_MERGE;
          if (tok_flag.hit && tok_flag.fits) count_next = count - CW'(1);
          else tok_next = tok + IW'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (load) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    tok <= tok_next;
    if (in_valid && !in_stall) begin
      mode_r <= mode_t'(mode);
      addr_r <= ADDR_BITS'(range_address);
      size_r <= request_size;
      res_addr <= '0;
      res_size <= '0;
      res_ok <= 1'b0;
    end
    case (state)
      S_PREP: begin
        n_r <= clip ? LEN_BITS'(WB'(room) + WB'(1)) : size_r;
        last_r <= clip ? AMASK : addr_r + ADDR_BITS'(size_r) - ADDR_BITS'(1);
        if (size_r == '0 && (mode_r == MODE_RELEASE || mode_r == MODE_RESERVE)) begin
          res_ok <= 1'b1;
        end
      end
      S_SCAN: begin
        fitv <= fit_w;
        gev <= ge_w;
        splitv <= split_w;
      end
      S_APPLY: begin
        case (mode_r)
          MODE_ALLOC_LO: begin
            if (fit_any) begin
              res_addr <= 32'(rd_start);
              res_size <= size_r;
              res_ok <= 1'b1;
            end
          end
          MODE_ALLOC_HI: begin
            if (fit_any) begin
              res_addr <= 32'(rd_start + ADDR_BITS'(rd_len - size_r));
              res_size <= size_r;
              res_ok <= 1'b1;
            end
          end
          MODE_RELEASE: begin
            pos_r <= ge_first;
            ins_start_r <= addr_r;
            ins_len_r <= n_r;
            res_ok <= 1'b1;
          end
          default: begin
            if (!(split_any && full)) res_ok <= 1'b1;
            pos_r <= split_idx + IW'(1);
            ins_start_r <= last_r + ADDR_BITS'(1);
            ins_len_r <= LEN_BITS'(rd_elast - last_r);
          end
        endcase
      end
      default: ;
    endcase
    if (load) begin
      granted_address <= res_addr;
      granted_size <= res_size;
      ok <= res_ok;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= FULL)
    else $error("extent count above table depth");

  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_DONE))
    else $error("result raised outside done");

  a_merge_shrinks: assert property (@(posedge clk) disable iff (rst)
    (state == S_MERGE) |=> count <= $past(count))
    else $error("merge walk grew the table");

  a_compact_shrinks: assert property (@(posedge clk) disable iff (rst)
    (state == S_COMPACT && zero_any) |=> count == $past(count) - CW'(1))
    else $error("compaction lost count");

endmodule

FILE: dv/tb_free_extent_range_allocator.sv
module tb_free_extent_range_allocator;
  import frea_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NEXT = 16;
  localparam logic [30:0] LMAX = 31'h7fffffff;
  localparam int CYCLE_LIMIT = 900000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] mode = MODE_ALLOC_LO;
  logic [31:0] range_address = '0;
  logic [30:0] request_size = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [31:0] granted_address;
  logic [30:0] granted_size;
  logic ok;

  typedef struct packed {
    logic [31:0] addr;
    logic [30:0] size;
    logic        ok;
  } grant_t;

  logic [31:0] ext_base [NEXT];
  logic [30:0] ext_len [NEXT];
  int ext_num;
  grant_t pending_grants[$];
  int errors = 0;
  int items_sent = 0;
  int grants_seen = 0;
  int cycles = 0;
  bit idle_on = 1'b1;
  int hold_cycles = 0;

  free_extent_range_allocator i_dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // table helpers
  function automatic void tab_drop(int i);
    if (i >= ext_num) return;
    for (int k = i; k + 1 < ext_num; k++) begin
      ext_base[k] = ext_base[k+1];
      ext_len[k] = ext_len[k+1];
    end
    ext_num--;
  endfunction

  function automatic void tab_put(int i, logic [31:0] s, logic [30:0] l);
    if (ext_num >= NEXT || i > ext_num) return;
    for (int k = ext_num; k > i; k--) begin
      ext_base[k] = ext_base[k-1];
      ext_len[k] = ext_len[k-1];
    end
    ext_base[i] = s;
    ext_len[i] = l;
    ext_num++;
  endfunction

  function automatic logic [30:0] clip(logic [31:0] a, logic [30:0] n);
    logic [32:0] room;
    room = 33'h0ffffffff - a;
    if ({2'b0, n} - 33'd1 > room) return room[30:0] + 31'd1;
    return n;
  endfunction

  function automatic void merge_table();
    int i;
    logic [32:0] gap, la, lb, top, total;
    i = 0;
    while (i < ext_num) begin
      if (ext_len[i] == 0) begin
        tab_drop(i);
        continue;
      end
      if (i + 1 < ext_num) begin
        if (ext_len[i+1] == 0) begin
          tab_drop(i + 1);
          continue;
        end
        gap = {1'b0, ext_base[i+1]} - {1'b0, ext_base[i]};
        if (gap <= {2'b0, ext_len[i]}) begin
          la = {1'b0, ext_base[i]} + ext_len[i] - 1;
          lb = {1'b0, ext_base[i+1]} + ext_len[i+1] - 1;
          top = la > lb ? la : lb;
          total = top - ext_base[i] + 1;
          if (total <= {2'b0, LMAX}) begin
            ext_len[i] = total[30:0];
            tab_drop(i + 1);
            continue;
          end
          ext_len[i] = LMAX;
          ext_base[i+1] = ext_base[i] + LMAX;
          ext_len[i+1] = 31'(total - LMAX);
        end
      end
      i++;
    end
  endfunction

  function automatic bit carve_range(logic [31:0] a, logic [30:0] n);
    logic [32:0] rlast, s, elast;
    int i;
    rlast = {1'b0, a} + n - 1;
    i = 0;
    while (i < ext_num) begin
      s = ext_base[i];
      elast = s + ext_len[i] - 1;
      if (a <= elast && rlast >= s) begin
        if (s < a && elast > rlast) begin
          if (ext_num >= NEXT) return 1'b0;
          ext_len[i] = 31'(a - s);
          tab_put(i + 1, 32'(rlast + 1), 31'(elast - rlast));
          i += 2;
          continue;
        end else if (a <= s) begin
          if (rlast >= elast) begin
            tab_drop(i);
            continue;
          end
          ext_base[i] = 32'(rlast + 1);
          ext_len[i] = 31'(elast - rlast);
        end else begin
          ext_len[i] = 31'(a - s);
        end
      end
      i++;
    end
    return 1'b1;
  endfunction

  function automatic grant_t predict_grant(logic [1:0] m, logic [31:0] a, logic [30:0] n);
    grant_t g;
    int i;
    g = '0;
    case (m)
      MODE_ALLOC_LO: begin
        if (n != 0)
          for (i = 0; i < ext_num; i++)
            if (ext_len[i] >= n) begin
              g = '{ext_base[i], n, 1'b1};
              ext_base[i] += n;
              ext_len[i] -= n;
              if (ext_len[i] == 0) tab_drop(i);
              break;
            end
      end
      MODE_ALLOC_HI: begin
        if (n != 0)
          for (i = ext_num - 1; i >= 0; i--)
            if (ext_len[i] >= n) begin
              ext_len[i] -= n;
              g = '{ext_base[i] + ext_len[i], n, 1'b1};
              if (ext_len[i] == 0) tab_drop(i);
              break;
            end
      end
      MODE_RELEASE: begin
        if (n == 0) g.ok = 1'b1;
        else if (ext_num < NEXT) begin
          i = 0;
          while (i < ext_num && ext_base[i] < a) i++;
          tab_put(i, a, clip(a, n));
          merge_table();
          g.ok = 1'b1;
        end
      end
      default: begin
        if (n == 0) g.ok = 1'b1;
        else g.ok = carve_range(a, clip(a, n));
      end
    endcase
    return g;
  endfunction

  task automatic send_request(logic [1:0] m, logic [31:0] a, logic [30:0] n);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 18);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    mode <= m;
    range_address <= a;
    request_size <= n;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_grants.push_back(predict_grant(m, a, n));
    items_sent++;
  endtask

  // receiver: random stalls, or one long hold when asked
  always @(posedge clk) begin
    if (rst) out_stall <= 1'b0;
    else if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else if (!idle_on) out_stall <= 1'b0;
    else if (out_stall) out_stall <= ($urandom_range(0, 5) != 0);
    else out_stall <= ($urandom_range(0, 7) == 0);
  end

  always @(posedge clk) begin
    grant_t e;
    if (!rst && out_valid && !out_stall) begin
      grants_seen++;
      if (pending_grants.size() == 0) begin
        $error("unexpected item: addr %h size %h ok %b", granted_address, granted_size, ok);
        errors++;
      end else begin
        e = pending_grants.pop_front();
        if (granted_address !== e.addr) begin
          $error("granted_address expected %h actual %h", e.addr, granted_address);
          errors++;
        end
        if (granted_size !== e.size) begin
          $error("granted_size expected %h actual %h", e.size, granted_size);
          errors++;
        end
        if (ok !== e.ok) begin
          $error("ok expected %b actual %b", e.ok, ok);
          errors++;
        end
      end
    end
  end

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_grants.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    send_request(MODE_ALLOC_LO, 0, 5);
    send_request(MODE_ALLOC_HI, 0, 5);
    send_request(MODE_RELEASE, 32'h100, 0);
    send_request(MODE_RESERVE, 32'h100, 0);
    send_request(MODE_RELEASE, 32'h1000, 32'h100);
    send_request(MODE_ALLOC_LO, 0, 0);
    send_request(MODE_ALLOC_LO, 32'hffffffff, 32'h10);
    send_request(MODE_ALLOC_HI, 0, 32'h10);
    send_request(MODE_RESERVE, 32'h1040, 32'h10);
    send_request(MODE_RELEASE, 32'h1030, 32'h30);
    send_request(MODE_ALLOC_LO, 0, 32'hc0);
    send_request(MODE_ALLOC_HI, 0, 32'h30);
    send_request(MODE_RELEASE, 32'hfffffff0, LMAX);
    send_request(MODE_RESERVE, 32'hfffffff8, LMAX);
    send_request(MODE_RELEASE, 32'h0, LMAX);
    send_request(MODE_RELEASE, 32'h7fff0000, 32'h20000);
    send_request(MODE_RELEASE, 32'h7fffff00, LMAX);
    send_request(MODE_RESERVE, 32'h0, LMAX);
    send_request(MODE_ALLOC_HI, 0, LMAX);
    send_request(MODE_ALLOC_LO, 0, LMAX);
    send_request(MODE_RESERVE, 32'h0, LMAX);
    send_request(MODE_RESERVE, 32'h80000000, LMAX);
    send_request(MODE_RESERVE, 32'hffffffff, LMAX);
    drain();
  endtask

  task automatic test_full_table();
    for (int k = 0; k < 17; k++) send_request(MODE_RELEASE, k * 32'h100, 32'h10);
    send_request(MODE_RELEASE, 32'h10, 32'h4);
    send_request(MODE_RESERVE, 32'h204, 32'h4);
    send_request(MODE_RESERVE, 32'h200, 32'h4);
    send_request(MODE_RESERVE, 32'h304, 32'h4);
    drain();
  endtask

  task automatic test_long_hold();
    hold_cycles <= 400;
    for (int k = 0; k < 20; k++) send_request(MODE_RELEASE, k * 32'h40, 32'h8);
    drain();
    send_request(MODE_RESERVE, 0, LMAX);
    drain();
  endtask

  task automatic test_random(int count);
    logic [31:0] base;
    logic [1:0] m;
    logic [30:0] n;
    base = $urandom;
    for (int k = 0; k < count; k++) begin
      m = 2'($urandom_range(0, 3));
      case ($urandom_range(0, 9))
        0: n = 31'($urandom);
        1: n = 0;
        default: n = 31'($urandom_range(1, 64));
      endcase
      if ($urandom_range(0, 9) == 0) send_request(m, $urandom, n);
      else send_request(m, base + $urandom_range(0, 2047), n);
      if (k % 200 == 199) base = $urandom;
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_full_table();
    test_long_hold();
    test_random(700);
    drain();
    idle_on = 1'b0;
    test_random(250);
    drain();
    repeat (60) @(posedge clk);
    $display("covered %0d requests, %0d results: allocate low/high, release with merge,",
             items_sent, grants_seen);
    $display("reserve with split, full table, length cap, address top and long output hold");
    if (errors == 0 && pending_grants.size() == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
